// File: sv/vcsp_pkg.sv
package vcsp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 32;
  localparam int unsigned ChunkW    = 7;
  localparam int unsigned StepW     = 3;

  localparam logic [StepW-1:0] StepLast = 3'd5;

  localparam logic [ByteW-1:0] OpStream    = 8'h54;
  localparam logic [ByteW-1:0] OpNode      = 8'h10;
  localparam logic [ByteW-1:0] TypeSurface = 8'h07;
  localparam logic [ByteW-1:0] MaxLenReset = 8'd127;

  typedef enum logic [3:0] {
    PH_OPCODE,
    PH_S_ID,
    PH_S_TYPE,
    PH_S_LEN,
    PH_S_TEXT,
    PH_N_ID,
    PH_N_TYPE,
    PH_N_PARENT,
    PH_N_REF
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_TEXT   = 2'd1,
    KIND_NODE   = 2'd2,
    KIND_TRUNC  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [WordW-1:0] acc;
    logic [StepW-1:0] step;
    logic             ovf;
    logic             done;
  } vint_t;

  typedef struct packed {
    kind_e            kind;
    logic [WordW-1:0] ident;
    logic [ByteW-1:0] item_type;
    logic [WordW-1:0] parent_ident;
    logic [WordW-1:0] stream_ref;
    logic             has_stream_ref;
    logic [WordW-1:0] text_length;
    logic             text_kept;
    logic [ByteW-1:0] text_byte;
    logic             overflow;
    logic             last;
  } res_t;

endpackage

// File: sv/vcsp_varint.sv
module vcsp_varint (
  input  logic [vcsp_pkg::WordW-1:0] acc_i,
  input  logic [vcsp_pkg::StepW-1:0] step_i,
  input  logic [vcsp_pkg::ByteW-1:0] byte_i,
  output vcsp_pkg::vint_t            vint_o
);
  import vcsp_pkg::*;

  logic [ChunkW-1:0] chunk;

  assign chunk = byte_i[ChunkW-1:0];

  // Each step places the next 7-bit group; groups past bit 31 only raise the overflow flag.
  always_comb begin
    vint_o.acc  = acc_i;
    vint_o.ovf  = 1'b0;
    vint_o.done = ~byte_i[ByteW-1];
    vint_o.step = (step_i >= StepLast) ? StepLast : step_i + 3'd1;
    unique case (step_i)
      3'd0: vint_o.acc = acc_i | {25'd0, chunk};
      3'd1: vint_o.acc = acc_i | {18'd0, chunk, 7'd0};
      3'd2: vint_o.acc = acc_i | {11'd0, chunk, 14'd0};
      3'd3: vint_o.acc = acc_i | {4'd0, chunk, 21'd0};
      3'd4: begin
        vint_o.acc = acc_i | {chunk[3:0], 28'd0};
        vint_o.ovf = |chunk[6:4];
      end
      default: vint_o.ovf = |chunk;
    endcase
  end

endmodule

// File: sv/vcsp_core.sv
module vcsp_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [vcsp_pkg::ByteW-1:0] byte_i,
  input  logic                       last_i,
  input  logic [vcsp_pkg::ByteW-1:0] max_len_i,
  output vcsp_pkg::res_t             res_o,
  output logic                       res_valid_o
);
  import vcsp_pkg::*;

  phase_e           phase_q, phase_d;
  logic [WordW-1:0] acc_q, acc_d;
  logic [StepW-1:0] step_q, step_d;
  logic [WordW-1:0] ident_q, ident_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [WordW-1:0] parent_q, parent_d;
  logic [WordW-1:0] remain_q, remain_d;
  logic             passing_q, passing_d;
  logic             ovf_q, ovf_d;
  logic             lenovf_q, lenovf_d;
  vint_t            vint;
  logic             cmd_done;
  logic             emit;
  logic             len_keep;

  vcsp_varint u_varint (
    .acc_i  (acc_q),
    .step_i (step_q),
    .byte_i (byte_i),
    .vint_o (vint)
  );

  assign len_keep = ~(lenovf_q | vint.ovf) && (vint.acc <= {24'd0, max_len_i});

  always_comb begin
    unique case (phase_q)
      PH_OPCODE:   cmd_done = (byte_i != OpStream) && (byte_i != OpNode);
      PH_S_LEN:    cmd_done = vint.done && (vint.acc == '0);
      PH_S_TEXT:   cmd_done = (remain_q == 32'd1);
      PH_N_PARENT: cmd_done = vint.done && (type_q != TypeSurface);
      PH_N_REF:    cmd_done = vint.done;
      default:     cmd_done = 1'b0;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_OPCODE: begin
        if (byte_i == OpStream) begin
          phase_d = PH_S_ID;
        end else if (byte_i == OpNode) begin
          phase_d = PH_N_ID;
        end
      end
      PH_S_ID:     if (vint.done) phase_d = PH_S_TYPE;
      PH_N_ID:     if (vint.done) phase_d = PH_N_TYPE;
      PH_S_TYPE:   phase_d = PH_S_LEN;
      PH_S_LEN:    if (vint.done) phase_d = PH_S_TEXT;
      PH_N_TYPE:   phase_d = PH_N_PARENT;
      PH_N_PARENT: if (vint.done) phase_d = PH_N_REF;
      default:     phase_d = phase_q;
    endcase
    if (cmd_done || last_i) begin
      phase_d = PH_OPCODE;
    end
  end

  always_comb begin
    acc_d     = acc_q;
    step_d    = step_q;
    ident_d   = ident_q;
    type_d    = type_q;
    parent_d  = parent_q;
    remain_d  = remain_q;
    passing_d = passing_q;
    ovf_d     = ovf_q;
    lenovf_d  = lenovf_q;
    emit      = 1'b0;
    res_o     = '0;
    unique case (phase_q)
      PH_OPCODE: begin
        ovf_d  = 1'b0;
        acc_d  = '0;
        step_d = '0;
      end
      PH_S_ID, PH_N_ID: begin
        acc_d    = vint.acc;
        step_d   = vint.step;
        ovf_d    = ovf_q | vint.ovf;
        lenovf_d = lenovf_q | vint.ovf;
        if (vint.done) begin
          ident_d = vint.acc;
          acc_d   = '0;
          step_d  = '0;
        end
      end
      PH_S_TYPE: begin
        type_d   = byte_i;
        lenovf_d = 1'b0;
      end
      PH_S_LEN: begin
        acc_d    = vint.acc;
        step_d   = vint.step;
        ovf_d    = ovf_q | vint.ovf;
        lenovf_d = lenovf_q | vint.ovf;
        if (vint.done) begin
          acc_d             = '0;
          step_d            = '0;
          remain_d          = vint.acc;
          passing_d         = len_keep;
          emit              = 1'b1;
          res_o.kind        = KIND_HEADER;
          res_o.ident       = ident_q;
          res_o.item_type   = type_q;
          res_o.text_length = vint.acc;
          res_o.text_kept   = len_keep;
          res_o.last        = cmd_done;
        end
      end
      PH_S_TEXT: begin
        remain_d = remain_q - 32'd1;
        if (passing_q) begin
          emit            = 1'b1;
          res_o.kind      = KIND_TEXT;
          res_o.ident     = ident_q;
          res_o.item_type = type_q;
          res_o.text_byte = byte_i;
          res_o.last      = cmd_done;
        end
      end
      PH_N_TYPE: type_d = byte_i;
      PH_N_PARENT, PH_N_REF: begin
        acc_d    = vint.acc;
        step_d   = vint.step;
        ovf_d    = ovf_q | vint.ovf;
        lenovf_d = lenovf_q | vint.ovf;
        if (vint.done) begin
          acc_d  = '0;
          step_d = '0;
          if (phase_q == PH_N_PARENT) begin
            parent_d = vint.acc;
          end
          if (cmd_done) begin
            emit               = 1'b1;
            res_o.kind         = KIND_NODE;
            res_o.ident        = ident_q;
            res_o.item_type    = type_q;
            res_o.parent_ident = (phase_q == PH_N_PARENT) ? vint.acc : parent_q;
            res_o.stream_ref   = (phase_q == PH_N_REF) ? vint.acc : '0;
            res_o.has_stream_ref = (phase_q == PH_N_REF);
            res_o.last         = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res_o.overflow = ovf_d;
    if (!cmd_done && last_i) begin
      // A payload that ends inside a command replaces any result with an error.
      emit           = 1'b1;
      res_o          = '0;
      res_o.kind     = KIND_TRUNC;
      res_o.overflow = ovf_d;
      res_o.last     = 1'b1;
      acc_d          = '0;
      step_d         = '0;
      remain_d       = '0;
      passing_d      = 1'b0;
    end
    res_valid_o = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_OPCODE;
      acc_q     <= '0;
      step_q    <= '0;
      ident_q   <= '0;
      type_q    <= '0;
      parent_q  <= '0;
      remain_q  <= '0;
      passing_q <= 1'b0;
      ovf_q     <= 1'b0;
      lenovf_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      step_q    <= step_d;
      ident_q   <= ident_d;
      type_q    <= type_d;
      parent_q  <= parent_d;
      remain_q  <= remain_d;
      passing_q <= passing_d;
      ovf_q     <= ovf_d;
      lenovf_q  <= lenovf_d;
    end
  end

endmodule

// File: sv/vcsp_outreg.sv
module vcsp_outreg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic           res_valid_i,
  input  vcsp_pkg::res_t res_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output vcsp_pkg::res_t res_o
);
  import vcsp_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // An item is taken only when this register is empty or draining.
  assign valid_d = fire_i ? res_valid_i : (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: sv/varint_command_stream_parser.sv
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o  | in_byte_i, in_last_i
// out     | output    | out_valid_o / out_stall_i| kind_o ... last_o
// cfg     | input     | cfg_we_i                 | cfg_wdata_i (max text length)
//
// Each byte is parsed as it is accepted, one byte per cycle unless stalled.
// The result appears on the output register in the cycle after its byte.
// A new byte is accepted while the output register is empty or being taken.
// Reset clears the parser to expect an opcode and the limit to 127.
// While the output is stalled with a result waiting, the input is stalled.
module varint_command_stream_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [vcsp_pkg::ByteW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [vcsp_pkg::ByteW-1:0] in_byte_i,
  input  logic                       in_last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 kind_o,
  output logic [vcsp_pkg::WordW-1:0] ident_o,
  output logic [vcsp_pkg::ByteW-1:0] item_type_o,
  output logic [vcsp_pkg::WordW-1:0] parent_ident_o,
  output logic [vcsp_pkg::WordW-1:0] stream_ref_o,
  output logic                       has_stream_ref_o,
  output logic [vcsp_pkg::WordW-1:0] text_length_o,
  output logic                       text_kept_o,
  output logic [vcsp_pkg::ByteW-1:0] text_byte_o,
  output logic                       overflow_o,
  output logic                       last_o
);
  import vcsp_pkg::*;

  logic [ByteW-1:0] max_len_q;
  logic             fire;
  logic             res_valid;
  res_t             res_comb;
  res_t             res_out;

  assign in_stall_o = out_valid_o & out_stall_i;
  assign fire       = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  vcsp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_i),
    .last_i      (in_last_i),
    .max_len_i   (max_len_q),
    .res_o       (res_comb),
    .res_valid_o (res_valid)
  );

  vcsp_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (res_comb),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign kind_o           = res_out.kind;
  assign ident_o          = res_out.ident;
  assign item_type_o      = res_out.item_type;
  assign parent_ident_o   = res_out.parent_ident;
  assign stream_ref_o     = res_out.stream_ref;
  assign has_stream_ref_o = res_out.has_stream_ref;
  assign text_length_o    = res_out.text_length;
  assign text_kept_o      = res_out.text_kept;
  assign text_byte_o      = res_out.text_byte;
  assign overflow_o       = res_out.overflow;
  assign last_o           = res_out.last;

endmodule

// File: sv/vcsp_checker.sv
module vcsp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [1:0]                 kind_o,
  input logic [vcsp_pkg::WordW-1:0] ident_o,
  input logic [vcsp_pkg::WordW-1:0] parent_ident_o,
  input logic [vcsp_pkg::WordW-1:0] stream_ref_o,
  input logic                       has_stream_ref_o,
  input logic [vcsp_pkg::WordW-1:0] text_length_o,
  input logic                       last_o
);
  import vcsp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(ident_o))
    else $error("Stalled result item changed or vanished.");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled without a waiting result item.");

  a_text_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_TEXT |->
      parent_ident_o == '0 && stream_ref_o == '0 && text_length_o == '0 && !has_stream_ref_o)
    else $error("Text item carries header or node fields.");

  a_trunc_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_TRUNC || kind_o == KIND_NODE) |-> last_o)
    else $error("Node or error item does not end its command.");

endmodule

bind varint_command_stream_parser vcsp_checker u_vcsp_checker (.*);
